/* src/pfc_pkg.sv */
// shared types, register codes and conversion helpers for the pixel format converter
`default_nettype none

package pfc_pkg;

    // configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int PIXEL_W     = 32;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_ORDER = 2'd1
    } cfg_index_t;

    // conversion modes
    typedef enum logic [2:0] {
        MODE_PREMUL      = 3'd0,
        MODE_RGBA_TO_ARGB = 3'd1,
        MODE_ARGB_TO_RGBA = 3'd2,
        MODE_RGB565      = 3'd3,
        MODE_GRAY        = 3'd4,
        MODE_GRAY_EXPAND = 3'd5
    } conv_mode_t;

    // live configuration handed to the datapath
    typedef struct packed {
        logic [2:0] mode;
        logic       native_order;
    } pfc_cfg_t;

    // opaque alpha
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // luma weights, 16 fraction bits, summing to one
    localparam logic [15:0] GRAY_COEF_R = 16'd19595;
    localparam logic [15:0] GRAY_COEF_G = 16'd38470;
    localparam logic [15:0] GRAY_COEF_B = 16'd7471;

    // 5-bit channel scaled by 255/31, truncated
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // 6-bit channel scaled by 255/63: 4c plus floor(c/21)
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [1:0] extra;
        begin
            if (c >= 6'd63)
            begin
                extra = 2'd3;
            end
            else if (c >= 6'd42)
            begin
                extra = 2'd2;
            end
            else if (c >= 6'd21)
            begin
                extra = 2'd1;
            end
            else
            begin
                extra = 2'd0;
            end
            expand6 = {c, 2'b00} + {6'd0, extra};
        end
    endfunction

    // channel times alpha over 255, truncated, without a divider
    function automatic logic [7:0] mul_div255(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] prod;
        logic [16:0] t;
        logic [16:0] s;
        begin
            prod       = c * a;
            t          = {1'b0, prod} + 17'd1;
            s          = t + {8'd0, t[16:8]};
            mul_div255 = s[15:8];
        end
    endfunction

endpackage

`default_nettype wire

/* src/pfc_cfg_regs.sv */
// configuration registers: conversion mode and byte order
`default_nettype none

module pfc_cfg_regs
    import pfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output      logic                   cfg_ready,
    output      pfc_cfg_t               cfg
);

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       order_reg;
    logic       order_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register decode
    always_comb
    begin
        mode_next  = mode_reg;
        order_next = order_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MODE:  mode_next  = cfg_data[2:0];
                REG_ORDER: order_next = cfg_data[0];
                default:   ;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PREMUL;
            order_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            order_reg <= order_next;
        end
    end

    assign cfg.mode         = mode_reg;
    assign cfg.native_order = order_reg;

endmodule

`default_nettype wire

/* src/pfc_convert.sv */
// combinational pixel conversion for all modes
`default_nettype none

module pfc_convert
    import pfc_pkg::*;
(
    input  wire logic [PIXEL_W-1:0] pixel,
    input  wire pfc_cfg_t           cfg,
    output      logic [PIXEL_W-1:0] result
);

    logic [7:0]  ra;
    logic [7:0]  rr;
    logic [7:0]  rg;
    logic [7:0]  rb;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
    logic [15:0] v565;
    logic [7:0]  e5r;
    logic [7:0]  e6g;
    logic [7:0]  e5b;
    logic [23:0] luma;
    logic [PIXEL_W-1:0] to_rgba;

    // rgba channel unpack in either byte order
    always_comb
    begin
        if (cfg.native_order)
        begin
            rr = pixel[31:24];
            rg = pixel[23:16];
            rb = pixel[15:8];
            ra = pixel[7:0];
        end
        else
        begin
            ra = pixel[31:24];
            rb = pixel[23:16];
            rg = pixel[15:8];
            rr = pixel[7:0];
        end
    end

    // premultiplied colour channels
    assign pr = mul_div255(rr, ra);
    assign pg = mul_div255(rg, ra);
    assign pb = mul_div255(rb, ra);

    // argb to rgba repack
    assign to_rgba = cfg.native_order
                   ? {pixel[23:16], pixel[15:8], pixel[7:0], pixel[31:24]}
                   : {pixel[31:24], pixel[7:0], pixel[15:8], pixel[23:16]};

    // rgb565 unpack and expand
    assign v565 = cfg.native_order ? pixel[15:0] : {pixel[7:0], pixel[15:8]};
    assign e5r  = EXPAND5_LUT[v565[15:11]];
    assign e6g  = expand6(v565[10:5]);
    assign e5b  = EXPAND5_LUT[v565[4:0]];

    // weighted luma sum
    assign luma = (24'(GRAY_COEF_R) * 24'(pixel[23:16]))
                + (24'(GRAY_COEF_G) * 24'(pixel[15:8]))
                + (24'(GRAY_COEF_B) * 24'(pixel[7:0]));

    // mode select
    always_comb
    begin
        case (conv_mode_t'(cfg.mode))
            MODE_PREMUL:       result = {ra, pr, pg, pb};
            MODE_RGBA_TO_ARGB: result = {ra, rr, rg, rb};
            MODE_ARGB_TO_RGBA: result = to_rgba;
            MODE_RGB565:       result = {ALPHA_OPAQUE, e5r, e6g, e5b};
            MODE_GRAY:         result = {24'd0, luma[23:16]};
            MODE_GRAY_EXPAND:  result = {ALPHA_OPAQUE, pixel[7:0], pixel[7:0], pixel[7:0]};
            default:           result = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/pixel_format_converter.sv */
// Pixel format converter: takes one 32-bit pixel beat per clock when start is high
// (busy stays low, so every start is taken) and returns the converted pixel on pixel_out
// with done high for exactly one cycle. One pixel per clock is sustained. The path
// holds two registers, input register then result register, with the whole
// conversion done in the logic between them. The receiver
// cannot stall the output. Mode and byte order are written through the cfg_* port
// (always ready) and should only change while no pixel is in flight.
`default_nettype none

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire logic [PIXEL_W-1:0]     pixel_in,
    output      logic [PIXEL_W-1:0]     pixel_out,
    output      logic                   done,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    pfc_cfg_t           cfg;
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] in_pixel_reg;
    logic               done_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [PIXEL_W-1:0] conv_next;

    // a new pixel every cycle
    assign busy = 1'b0;

    // configuration registers
    pfc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // conversion datapath
    pfc_convert u_conv
    (
        .pixel  (in_pixel_reg),
        .cfg    (cfg),
        .result (conv_next)
    );

    // input and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_pixel_reg <= pixel_in;
        end
        if (in_valid_reg)
        begin
            out_pixel_reg <= conv_next;
        end
    end

    assign done      = done_reg;
    assign pixel_out = out_pixel_reg;

endmodule

`default_nettype wire

/* src/pfc_checker.sv */
// port-level checks on the pixel format converter and its bind
`default_nettype none

module pfc_checker
    import pfc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic [PIXEL_W-1:0]     pixel_in,
    input wire logic [PIXEL_W-1:0]     pixel_out,
    input wire logic                   done,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready
);

    // every accepted beat gives exactly one result, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $past(rst_n, 2)) |-> (done == $past(start && !busy, 2)))
        else $error("result strobe does not follow accepted beat by two cycles");

    // no result without an accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted beat");

    // equal back-to-back pixels under the same settings convert alike
    a_same_in_same_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && $past(rst_n, 3)
         && ($past(pixel_in, 2) == $past(pixel_in, 3))
         && !$past(cfg_valid && cfg_ready, 2))
        |-> (pixel_out == $past(pixel_out)))
        else $error("same pixel and settings gave different results");

    // block never stalls the source
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised against a start");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* test/pixel_format_converter_tb.sv */
// testbench for the pixel format converter: directed pixel table, then random phases per mode
`default_nettype none

module pixel_format_converter_tb;
    import pfc_pkg::*;

    // mode codes with no conversion behind them, and register indexes with no register
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int PIPE_DEPTH     = 2;
    localparam int STALL_LIMIT    = 500;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 102;
    localparam int CALM_PHASES    = 2;
    localparam int DIRECTED_ROWS  = 23;

    // one directed row: configuration, optional stray register writes, pixel, known answer
    typedef struct packed {
        logic [2:0]         mode;
        logic               order;
        logic               stray;
        logic [PIXEL_W-1:0] pix;
        logic               known;
        logic [PIXEL_W-1:0] want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_PREMUL,       1'b0, 1'b0, 32'hFF000000, 1'b1, 32'hFF000000},
        '{MODE_PREMUL,       1'b0, 1'b0, 32'hFF123456, 1'b1, 32'hFF563412},
        '{MODE_PREMUL,       1'b0, 1'b0, 32'h00FFFFFF, 1'b1, 32'h00000000},
        '{MODE_PREMUL,       1'b0, 1'b0, 32'h80FFFFFF, 1'b0, 32'h00000000},
        '{MODE_PREMUL,       1'b1, 1'b0, 32'h11223380, 1'b0, 32'h00000000},
        '{MODE_PREMUL,       1'b1, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{MODE_RGBA_TO_ARGB, 1'b0, 1'b0, 32'h11223344, 1'b1, 32'h11443322},
        '{MODE_RGBA_TO_ARGB, 1'b1, 1'b0, 32'h11223344, 1'b1, 32'h44112233},
        '{MODE_ARGB_TO_RGBA, 1'b0, 1'b0, 32'h11223344, 1'b1, 32'h11443322},
        '{MODE_ARGB_TO_RGBA, 1'b1, 1'b0, 32'h11223344, 1'b1, 32'h22334411},
        '{MODE_RGB565,       1'b0, 1'b0, 32'hFFFF0000, 1'b1, 32'hFF000000},
        '{MODE_RGB565,       1'b1, 1'b0, 32'h0000FFFF, 1'b1, 32'hFFFFFFFF},
        '{MODE_RGB565,       1'b0, 1'b0, 32'h0000FFFF, 1'b1, 32'hFFFFFFFF},
        '{MODE_RGB565,       1'b1, 1'b0, 32'h00001234, 1'b0, 32'h00000000},
        '{MODE_RGB565,       1'b0, 1'b0, 32'h00001234, 1'b0, 32'h00000000},
        '{MODE_GRAY,         1'b0, 1'b0, 32'h00FFFFFF, 1'b1, 32'h000000FF},
        '{MODE_GRAY,         1'b0, 1'b0, 32'hFF000000, 1'b1, 32'h00000000},
        '{MODE_GRAY,         1'b0, 1'b0, 32'h12345678, 1'b0, 32'h00000000},
        '{MODE_GRAY_EXPAND,  1'b0, 1'b0, 32'hFFFFFF80, 1'b1, 32'hFF808080},
        '{MODE_GRAY_EXPAND,  1'b1, 1'b0, 32'h00000000, 1'b1, 32'hFF000000},
        '{MODE_UNUSED_6,     1'b0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'h00000000},
        '{MODE_UNUSED_7,     1'b1, 1'b0, 32'h12345678, 1'b1, 32'h00000000},
        '{MODE_GRAY_EXPAND,  1'b1, 1'b1, 32'h000000FF, 1'b1, 32'hFFFFFFFF}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic [PIXEL_W-1:0]     pixel_in  = '0;
    logic [PIXEL_W-1:0]     pixel_out;
    logic                   done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // known answer travelling with the pixel beat, if the row has one
    logic                   known_beat = 1'b0;
    logic [PIXEL_W-1:0]     known_want = '0;

    // predictor's copy of the registers
    logic [2:0]             model_mode  = MODE_PREMUL;
    logic                   model_order = 1'b0;

    // values last written by the stimulus side
    logic [2:0]             set_mode  = MODE_PREMUL;
    logic                   set_order = 1'b0;

    logic [PIXEL_W-1:0]     pixel_due [$];
    int                     mismatch_count = 0;
    int                     quiet_cycles   = 0;

    pixel_format_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_in  (pixel_in),
        .pixel_out (pixel_out),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // expected converted pixel for the given mode and byte order
    function automatic logic [PIXEL_W-1:0] convert_pixel(input logic [2:0] mode,
                                                         input logic order,
                                                         input logic [PIXEL_W-1:0] p);
        logic [7:0]  a;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [15:0] v;
        logic [31:0] luma;
        begin
            convert_pixel = '0;
            case (mode)
                MODE_PREMUL, MODE_RGBA_TO_ARGB:
                begin
                    if (order)
                    begin
                        {r, g, b, a} = p;
                    end
                    else
                    begin
                        {a, b, g, r} = p;
                    end
                    if (mode == MODE_PREMUL && a != ALPHA_OPAQUE)
                    begin
                        r = 8'((32'(r) * 32'(a)) / 255);
                        g = 8'((32'(g) * 32'(a)) / 255);
                        b = 8'((32'(b) * 32'(a)) / 255);
                    end
                    convert_pixel = {a, r, g, b};
                end
                MODE_ARGB_TO_RGBA:
                begin
                    {a, r, g, b} = p;
                    convert_pixel = order ? {r, g, b, a} : {a, b, g, r};
                end
                MODE_RGB565:
                begin
                    // swapped layout exchanges the two bytes before unpacking
                    v = order ? p[15:0] : {p[7:0], p[15:8]};
                    r = 8'((32'(v[15:11]) * 255) / 31);
                    g = 8'((32'(v[10:5]) * 255) / 63);
                    b = 8'((32'(v[4:0]) * 255) / 31);
                    convert_pixel = {ALPHA_OPAQUE, r, g, b};
                end
                MODE_GRAY:
                begin
                    luma = 32'(GRAY_COEF_R) * 32'(p[23:16]) + 32'(GRAY_COEF_G) * 32'(p[15:8])
                         + 32'(GRAY_COEF_B) * 32'(p[7:0]);
                    convert_pixel = {24'd0, luma[23:16]};
                end
                MODE_GRAY_EXPAND:
                begin
                    convert_pixel = {ALPHA_OPAQUE, p[7:0], p[7:0], p[7:0]};
                end
                default:
                begin
                    convert_pixel = '0;
                end
            endcase
        end
    endfunction

    // random pixel, biased towards opaque, transparent and all-equal words
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] p;
        begin
            p = $urandom;
            case ($urandom_range(0, 9))
                0: p = p | 32'hFF0000FF;
                1: p = p & 32'h00FFFF00;
                2: p = '1;
                3: p = '0;
                default: ;
            endcase
            random_pixel = p;
        end
    endfunction

    // monitor: predict on every accepted beat, check every result, watch for stalls
    always @(posedge clk)
    begin : monitor
        logic [PIXEL_W-1:0] want;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (start && !busy)
            begin
                pixel_due.push_back(known_beat ? known_want
                                               : convert_pixel(model_mode, model_order, pixel_in));
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                begin
                    model_mode = cfg_data;
                end
                else if (cfg_index == REG_ORDER)
                begin
                    model_order = cfg_data[0];
                end
                quiet_cycles = 0;
            end
            if (done)
            begin
                quiet_cycles = 0;
                if (pixel_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("unexpected result: pixel_out %h", pixel_out);
                    end
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = pixel_due.pop_front();
                    if (pixel_out !== want)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: pixel_out expected %h actual %h", want, pixel_out);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // offer one pixel beat and hold it until taken
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic known,
                              input logic [PIXEL_W-1:0] want);
        begin
            @(negedge clk);
            start      <= 1'b1;
            pixel_in   <= pix;
            known_beat <= known;
            known_want <= want;
            do @(posedge clk); while (busy);
        end
    endtask

    // sender pause with noise on the pixel lines
    task automatic idle_gap(input int unsigned cycles);
        begin
            @(negedge clk);
            start    <= 1'b0;
            pixel_in <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending and wait until every pixel in flight has come back
    task automatic drain();
        begin
            @(negedge clk);
            start <= 1'b0;
            while (pixel_due.size() != 0) @(posedge clk);
            repeat (PIPE_DEPTH) @(posedge clk);
        end
    endtask

    // register write, only once the pipe is empty
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            drain();
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= index;
            cfg_data  <= data;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_config(input logic [2:0] mode, input logic order);
        begin
            write_reg(REG_MODE, mode);
            // upper data bits of the order register are don't-care
            write_reg(REG_ORDER, {2'($urandom_range(0, 3)), order});
            set_mode  = mode;
            set_order = order;
        end
    endtask

    // stimulus and final verdict
    initial
    begin : stimulus
        dir_row_t    row;
        logic [2:0]  mode;
        logic        order;
        int unsigned pause_at;
        bit          calm;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, first ones run on the reset configuration
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.mode != set_mode || row.order != set_order)
            begin
                set_config(row.mode, row.order);
            end
            if (row.stray)
            begin
                // writes to indexes with no register must leave both registers alone
                write_reg(REG_SPARE_A, 3'b110);
                write_reg(REG_SPARE_B, 3'b001);
            end
            send_pixel(row.pix, row.known, row.want);
        end

        // random phases over every mode code and both byte orders
        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode  = 3'(ph % 8);
            order = (ph / 8) != 0;
            calm  = ph >= PHASES - CALM_PHASES;
            set_config(mode, order);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 3'($urandom));
            end
            pause_at = $urandom_range(0, PHASE_ITEMS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == pause_at)
                begin
                    drain();
                end
                if (!calm && $urandom_range(0, 5) == 0)
                begin
                    idle_gap($urandom_range(1, 11));
                end
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end

        // let the pipe empty out
        @(negedge clk);
        start <= 1'b0;
        while (pixel_due.size() != 0) @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/pfc_pkg.sv
src/pfc_cfg_regs.sv
src/pfc_convert.sv
src/pixel_format_converter.sv
src/pfc_checker.sv
test/pixel_format_converter_tb.sv
